// ===== hdl/goertzel_band_level_analyzer_defines.svh =====
// assertion helpers, clocked on clk and quiet while arst_n is low
`ifndef GOERTZEL_BAND_LEVEL_ANALYZER_DEFINES_SVH
`define GOERTZEL_BAND_LEVEL_ANALYZER_DEFINES_SVH
`ifndef SYNTHESIS
`define GBLA_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("gbla assertion failed");
`define GBLA_ASSERT_NOW(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("gbla invariant failed");
`else
`define GBLA_ASSERT(lbl, prop)
`define GBLA_ASSERT_NOW(lbl, expr)
`endif
`endif

// ===== hdl/gbla_pkg.sv =====
package gbla_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int RES_W      = 40;
	localparam int T_W        = 29;
	localparam int COEF_W     = 18;
	localparam int BAND_IDX_W = 5;
	localparam int LEVEL_W    = 16;
	localparam int GAIN_W     = 16;
	localparam int KEEP_W     = 17;
	localparam int N_W        = 13;
	localparam int CFG_ADDR_W = 1;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = 2;
	localparam int TAB_LEN    = 18;
	localparam logic [KEEP_W-1:0] KEEP_ONE = 17'd65536;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd2816;
	localparam logic [KEEP_W-1:0] KEEP_RESET = 17'd52429;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_GAIN       = 1'b0,
		REG_DECAY_KEEP = 1'b1
	} cfg_reg_t;

	// one band's final resonator pair, handed from front to back
	typedef struct packed {
		logic signed [T_W-1:0]  t1;
		logic signed [T_W-1:0]  t2;
		logic [N_W-1:0]         n;
		logic [BAND_IDX_W-1:0]  band;
		logic                   last;
	} band_job_t;

	// 2*cos(2*pi*f/16000) in Q2.16, log-spaced 80 Hz .. 6 kHz
	localparam logic signed [COEF_W-1:0] COEF_TAB [TAB_LEN] = '{
		18'sd131007, 18'sd130965, 18'sd130893, 18'sd130775, 18'sd130579,
		18'sd130253, 18'sd129712, 18'sd128814, 18'sd127327, 18'sd124868,
		18'sd120818, 18'sd114176, 18'sd103401, 18'sd86195,  18'sd59476,
		18'sd19975,  -18'sd33308, -18'sd92682
	};

	function automatic logic signed [COEF_W-1:0] coef_of(input logic [BAND_IDX_W-1:0] b);
		if (b < BAND_IDX_W'(TAB_LEN)) begin
			return COEF_TAB[b];
		end
		return COEF_TAB[TAB_LEN-1];
	endfunction

	// round half up after dropping 12 bits
	function automatic logic signed [T_W-1:0] to_t(input logic signed [RES_W-1:0] v);
		logic signed [RES_W:0] tmp;
		tmp = (RES_W+1)'(v) + (RES_W+1)'(2048);
		return tmp[RES_W:12];
	endfunction

endpackage

// ===== hdl/gbla_front.sv =====
`include "goertzel_band_level_analyzer_defines.svh"

module gbla_front import gbla_pkg::*; #(
	parameter int BANDS     = 18,
	parameter int MAX_FRAME = 512
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [SAMPLE_W-1:0] s_tdata,    // [15:0] sample
	input  logic                s_tlast,    // frame_end
	output logic                job_valid,
	output band_job_t           job,
	input  logic                job_ready
);

	localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_ACC} fstate_t;

	fstate_t                  state_q;
	logic signed [RES_W-1:0]  prev_q [BANDS];
	logic signed [RES_W-1:0]  prev2_q [BANDS];
	logic signed [RES_W-1:0]  x_q;
	logic                     end_q;
	logic [N_W-1:0]           n_q;
	logic [N_W-1:0]           cnt_q;
	logic [BW-1:0]            band_q;
	logic signed [38:0]       plo_q;
	logic signed [37:0]       phi_q;

	logic signed [COEF_W-1:0] c;
	logic signed [RES_W-1:0]  s1, s2;
	logic signed [57:0]       psum;
	logic signed [41:0]       rnd;
	logic signed [43:0]       s0_full;
	logic signed [RES_W-1:0]  s0;
	logic [N_W-1:0]           cnt_inc;
	logic                     fin;
	logic                     band_last;

	assign c        = coef_of(BAND_IDX_W'(band_q));
	assign s1       = prev_q[band_q];
	assign s2       = prev2_q[band_q];
	assign psum     = (58'(phi_q) <<< 20) + 58'(plo_q);
	assign rnd      = 42'((psum + 58'sd32768) >>> 16);
	assign s0_full  = 44'(x_q) + 44'(rnd) - 44'(s2);
	assign s0       = s0_full[RES_W-1:0];
	assign cnt_inc  = cnt_q + N_W'(1);
	assign fin      = s_tlast || (cnt_inc == N_W'(MAX_FRAME));
	assign band_last = (band_q == BW'(BANDS - 1));

	assign s_tready  = (state_q == F_IDLE);
	assign job_valid = (state_q == F_ACC) && end_q;
	assign job.t1    = to_t(s0);
	assign job.t2    = to_t(s1);
	assign job.n     = n_q;
	assign job.band  = BAND_IDX_W'(band_q);
	assign job.last  = band_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
			band_q  <= '0;
			end_q   <= 1'b0;
			for (int i = 0; i < BANDS; i++) begin
				prev_q[i]  <= '0;
				prev2_q[i] <= '0;
			end
		end else begin
			case (state_q)
				F_IDLE: begin
					if (s_tvalid) begin
						x_q     <= RES_W'($signed(s_tdata)) <<< 9;
						end_q   <= fin;
						n_q     <= cnt_inc;
						cnt_q   <= fin ? '0 : cnt_inc;
						band_q  <= '0;
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					// split the 40-bit state so each product stays narrow
					plo_q   <= c * $signed({1'b0, s1[19:0]});
					phi_q   <= c * $signed(s1[39:20]);
					state_q <= F_ACC;
				end
				F_ACC: begin
					if (!end_q || job_ready) begin
						if (end_q) begin
							prev_q[band_q]  <= '0;
							prev2_q[band_q] <= '0;
						end else begin
							prev_q[band_q]  <= s0;
							prev2_q[band_q] <= s1;
						end
						if (band_last) begin
							state_q <= F_IDLE;
						end else begin
							band_q  <= band_q + BW'(1);
							state_q <= F_MUL;
						end
					end
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	`GBLA_ASSERT(a_front_job_in_frame_end, job_valid |-> (n_q != '0))

endmodule

// ===== hdl/gbla_fifo.sv =====
`include "goertzel_band_level_analyzer_defines.svh"

module gbla_fifo import gbla_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	input  band_job_t push_data,
	output logic      push_ready,
	output logic      pop_valid,
	output band_job_t pop_data,
	input  logic      pop_ready
);

	band_job_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_AW:0]   count_q;
	logic               push, pop;

	assign push_ready = (count_q != (FIFO_AW+1)'(FIFO_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = mem_q[rd_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + FIFO_AW'(1);
			end
			count_q <= count_q + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
		end
	end

	`GBLA_ASSERT_NOW(a_fifo_count_bound, count_q <= (FIFO_AW+1)'(FIFO_DEPTH))
	`GBLA_ASSERT_NOW(a_fifo_ptr_agree, (count_q == '0) ? (wr_q == rd_q) : 1'b1)

endmodule

// ===== hdl/gbla_back.sv =====
`include "goertzel_band_level_analyzer_defines.svh"

module gbla_back import gbla_pkg::*; #(
	parameter int BANDS = 18
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  band_job_t         job,
	output logic              job_ready,
	input  logic [GAIN_W-1:0] gain,
	input  logic [KEEP_W-1:0] keep,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [23:0]       m_tdata,   // [4:0] band_index, [20:5] level, rest zero
	output logic              m_tlast    // last_band
);

	localparam int BW = (BANDS > 1) ? $clog2(BANDS) : 1;

	typedef enum logic [4:0] {
		B_IDLE, B_SQ1, B_SQ2, B_PR, B_P, B_PLO, B_PHI, B_PSUM, B_E, B_SQRT,
		B_GAIN, B_NUM, B_DCHK, B_DIV, B_SM0, B_SM1, B_SM2, B_OUT
	} bstate_t;

	bstate_t                  state_q;
	logic signed [T_W-1:0]    t1_q, t2_q;
	logic [N_W-1:0]           n_q;
	logic [BAND_IDX_W-1:0]    band_q;
	logic                     last_q;
	logic signed [65:0]       prod_q;
	logic signed [57:0]       acc_q, sub_q;
	logic signed [RES_W-1:0]  p_q;
	logic [61:0]              sx_q, res_q, bit_q;
	logic [42:0]              num_q;
	logic [N_W-1:0]           rem_q;
	logic [15:0]              dq_q;
	logic [3:0]               cnt_q;
	logic [LEVEL_W-1:0]       v_q, nl_q;
	logic [LEVEL_W-1:0]       lvl_q [BANDS];
	logic                     m_valid_q;
	logic [LEVEL_W-1:0]       m_level_q;
	logic [BAND_IDX_W-1:0]    m_band_q;
	logic                     m_last_q;

	logic signed [32:0]       mul_a, mul_b;
	logic signed [COEF_W-1:0] c;
	logic [KEEP_W-1:0]        keep_eff;
	logic [KEEP_W-1:0]        keep_rest;
	logic [LEVEL_W-1:0]       prev;
	logic signed [65:0]       prnd;
	logic signed [57:0]       e;
	logic [61:0]              trial;
	logic [48:0]              num;
	logic [N_W:0]             r2;
	logic [57:0]              blend;

	assign c         = coef_of(band_q);
	assign keep_eff  = (keep > KEEP_ONE) ? KEEP_ONE : keep;
	assign keep_rest = KEEP_ONE - keep_eff;
	assign prev      = lvl_q[band_q[BW-1:0]];
	assign prnd      = prod_q + 66'sd32768;
	assign e         = acc_q - sub_q;
	assign trial     = res_q + bit_q;
	assign num       = {prod_q[47:0], 1'b0} + {31'd0, n_q, 5'd0};
	assign r2        = {rem_q, dq_q[15]};
	assign blend     = 58'(sub_q) + 58'(prod_q) + 58'd32768;

	// one shared multiplier, operands picked by step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			B_SQ1: begin
				mul_a = 33'(t1_q);
				mul_b = 33'(t1_q);
			end
			B_SQ2: begin
				mul_a = 33'(t2_q);
				mul_b = 33'(t2_q);
			end
			B_PR: begin
				mul_a = 33'(t1_q);
				mul_b = 33'(t2_q);
			end
			B_PLO: begin
				mul_a = $signed({13'd0, p_q[19:0]});
				mul_b = 33'(c);
			end
			B_PHI: begin
				mul_a = 33'($signed(p_q[39:20]));
				mul_b = 33'(c);
			end
			B_GAIN: begin
				mul_a = $signed({2'd0, res_q[30:0]});
				mul_b = $signed({17'd0, gain});
			end
			B_SM0: begin
				mul_a = $signed({17'd0, prev});
				mul_b = $signed({16'd0, keep_eff});
			end
			B_SM1: begin
				mul_a = $signed({17'd0, v_q});
				mul_b = $signed({16'd0, keep_rest});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign job_ready = (state_q == B_IDLE);
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = {3'd0, m_level_q, m_band_q};
	assign m_tlast   = m_last_q;

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			m_valid_q <= 1'b0;
			for (int i = 0; i < BANDS; i++) begin
				lvl_q[i] <= '0;
			end
		end else begin
			if (m_tready && state_q != B_OUT) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (job_valid) begin
						t1_q    <= job.t1;
						t2_q    <= job.t2;
						n_q     <= job.n;
						band_q  <= job.band;
						last_q  <= job.last;
						state_q <= B_SQ1;
					end
				end
				B_SQ1: state_q <= B_SQ2;
				B_SQ2: begin
					acc_q   <= 58'(prod_q);
					state_q <= B_PR;
				end
				B_PR: begin
					acc_q   <= acc_q + 58'(prod_q);
					state_q <= B_P;
				end
				B_P: begin
					p_q     <= prnd[55:16];
					state_q <= B_PLO;
				end
				B_PLO: state_q <= B_PHI;
				B_PHI: begin
					sub_q   <= 58'(prod_q);
					state_q <= B_PSUM;
				end
				B_PSUM: begin
					sub_q   <= sub_q + (58'(prod_q) <<< 20);
					state_q <= B_E;
				end
				B_E: begin
					// negative energy clamps to zero
					sx_q    <= e[57] ? '0 : {1'b0, e[56:0], 4'd0};
					res_q   <= '0;
					bit_q   <= 62'd1 << 60;
					state_q <= B_SQRT;
				end
				B_SQRT: begin
					if (sx_q >= trial) begin
						sx_q  <= sx_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						state_q <= B_GAIN;
					end
				end
				B_GAIN: state_q <= B_NUM;
				B_NUM: begin
					num_q   <= num[48:6];
					state_q <= B_DCHK;
				end
				B_DCHK: begin
					if (num_q[42:16] >= 27'(n_q)) begin
						v_q     <= '1;
						state_q <= B_SM0;
					end else begin
						rem_q   <= num_q[28:16];
						dq_q    <= num_q[15:0];
						cnt_q   <= '0;
						state_q <= B_DIV;
					end
				end
				B_DIV: begin
					if (r2 >= {1'b0, n_q}) begin
						rem_q <= N_W'(r2 - {1'b0, n_q});
						dq_q  <= {dq_q[14:0], 1'b1};
					end else begin
						rem_q <= r2[N_W-1:0];
						dq_q  <= {dq_q[14:0], 1'b0};
					end
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= B_SM0;
					end
				end
				B_SM0: begin
					if (state_q == B_SM0 && v_q > prev) begin
						nl_q    <= v_q;
						state_q <= B_OUT;
					end else begin
						state_q <= B_SM1;
					end
				end
				B_SM1: begin
					sub_q   <= 58'(prod_q);
					state_q <= B_SM2;
				end
				B_SM2: begin
					nl_q    <= blend[31:16];
					state_q <= B_OUT;
				end
				B_OUT: begin
					if (!m_valid_q || m_tready) begin
						m_valid_q              <= 1'b1;
						m_level_q              <= nl_q;
						m_band_q               <= band_q;
						m_last_q               <= last_q;
						lvl_q[band_q[BW-1:0]]  <= nl_q;
						state_q                <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
			// quotient bits land in v once the last division step is done
			if (state_q == B_DIV && cnt_q == 4'd15) begin
				v_q <= {dq_q[14:0], (r2 >= {1'b0, n_q})};
			end
		end
	end

	`GBLA_ASSERT(a_back_band_range, m_valid_q |-> (m_band_q < BAND_IDX_W'(BANDS)))
	`GBLA_ASSERT(a_back_last_is_top, (m_valid_q && m_last_q) |-> (m_band_q == BAND_IDX_W'(BANDS - 1)))
	`GBLA_ASSERT(a_back_rem_below_n, (state_q == B_DIV) |-> (rem_q < n_q))

endmodule

// ===== hdl/goertzel_band_level_analyzer.sv =====
// Goertzel band-level analyzer: signed Q15 samples enter on s_*, and BANDS resonators
// (log-spaced 80 Hz to 6 kHz at 16 kHz) update for each one. On a sample with s_tlast
// set, or the MAX_FRAME-th sample of a frame, one smoothed Q0.16 level per band leaves
// on m_*, band 0 first, with m_tlast on the highest band, and the resonators restart.
// The resonator unit has one multiplier pair and runs a multiply state and an
// accumulate state per band before it takes the next sample. The back end finds
// each band's level on one shared multiplier, with a 31-step square root and a
// 16-step division; a 4-entry queue sits between the two, and the front waits
// when it is full, so a frame-ending sample holds off input while the back end
// catches up, longer while m_tready is held low. The user must write gain (index 0)
// and decay_keep (index 1) only while idle; the block itself does not enforce it.

module goertzel_band_level_analyzer import gbla_pkg::*; #(
	parameter int BANDS     = 18,
	parameter int MAX_FRAME = 512
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [SAMPLE_W-1:0]   s_tdata,    // [15:0] sample
	input  logic                  s_tlast,    // frame_end
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [23:0]           m_tdata,    // [4:0] band_index, [20:5] level, rest zero
	output logic                  m_tlast,    // last_band
	input  logic                  cfg_we,
	input  logic [CFG_ADDR_W-1:0] cfg_addr,
	input  logic [KEEP_W-1:0]     cfg_wdata
);

	logic [GAIN_W-1:0] gain_q;
	logic [KEEP_W-1:0] keep_q;
	logic              fj_valid, fj_ready, bj_valid, bj_ready;
	band_job_t         fj, bj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
			keep_q <= KEEP_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_addr))
				REG_GAIN:       gain_q <= cfg_wdata[GAIN_W-1:0];
				REG_DECAY_KEEP: keep_q <= cfg_wdata;
				default:        ;
			endcase
		end
	end

	gbla_front #(
		.BANDS     (BANDS),
		.MAX_FRAME (MAX_FRAME)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.job_valid (fj_valid),
		.job       (fj),
		.job_ready (fj_ready)
	);

	gbla_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fj_valid),
		.push_data  (fj),
		.push_ready (fj_ready),
		.pop_valid  (bj_valid),
		.pop_data   (bj),
		.pop_ready  (bj_ready)
	);

	gbla_back #(
		.BANDS (BANDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (bj_valid),
		.job       (bj),
		.job_ready (bj_ready),
		.gain      (gain_q),
		.keep      (keep_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

// ===== tb/goertzel_band_level_analyzer_test.sv =====
module goertzel_band_level_analyzer_test;
	import gbla_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NB   = 18;
	localparam int MAXF = 512;

	typedef struct {
		logic [BAND_IDX_W-1:0] band;
		logic [LEVEL_W-1:0]    level;
		logic                  last;
	} band_level_t;

	typedef struct {
		logic [SAMPLE_W-1:0] smp;
		bit                  fe;
		bit                  typed;
		logic [LEVEL_W-1:0]  lvl;
	} dir_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [SAMPLE_W-1:0]   s_tdata = '0;    // [15:0] sample
	logic                  s_tlast = 1'b0;  // frame_end
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [23:0]           m_tdata;         // [4:0] band_index, [20:5] level
	logic                  m_tlast;         // last_band
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [KEEP_W-1:0]     cfg_wdata = '0;

	// predictor state
	longint              res1 [NB];
	longint              res2 [NB];
	int unsigned         band_lvl [NB];
	int unsigned         frame_cnt;
	logic [GAIN_W-1:0]   gain_q;
	logic [KEEP_W-1:0]   keep_q;
	band_level_t         pending_levels [$];

	int errors = 0;
	int words_in = 0;
	int frames_out = 0;
	int send_idle = 24;
	int recv_idle = 48;

	goertzel_band_level_analyzer DUT (.*);

	always #10 clk = ~clk;

	function automatic longint round_shr(longint v, int sh);
		return (v + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint wrap40(longint v);
		logic signed [RES_W-1:0] w;
		w = v[RES_W-1:0];
		return w;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv >>= 2;
		while (bitv != 0) begin
			if (x >= res + bitv) begin
				x -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	function automatic longint band_coef(int b);
		return COEF_TAB[b < TAB_LEN ? b : TAB_LEN - 1];
	endfunction

	task automatic predict_sample(logic [SAMPLE_W-1:0] smp, bit fe);
		longint x, c, s0, t1, t2, p, e;
		longint unsigned r, v, n, keep, nl;
		band_level_t lv;
		x = longint'(signed'(smp)) * 512;
		for (int b = 0; b < NB; b++) begin
			c = band_coef(b);
			s0 = x + round_shr(c * res1[b], 16) - res2[b];
			res2[b] = res1[b];
			res1[b] = wrap40(s0);
		end
		if (!fe && frame_cnt + 1 < MAXF) begin
			frame_cnt++;
			return;
		end
		n = frame_cnt + 1;
		keep = (keep_q > KEEP_ONE) ? 64'd65536 : 64'(keep_q);
		for (int b = 0; b < NB; b++) begin
			c = band_coef(b);
			t1 = round_shr(res1[b], 12);
			t2 = round_shr(res2[b], 12);
			p = round_shr(t1 * t2, 16);
			e = t1 * t1 + t2 * t2 - p * c;
			if (e < 0) e = 0;
			r = int_sqrt(longint'(unsigned'(e)) << 4);
			v = (2 * r * gain_q + n * 32) / (n * 64);
			if (v > 65535) v = 65535;
			if (v > band_lvl[b])
				nl = v;
			else
				nl = (band_lvl[b] * keep + v * (65536 - keep) + 32768) >> 16;
			band_lvl[b] = 32'(nl & 64'hFFFF);
			lv.band = BAND_IDX_W'(b);
			lv.level = LEVEL_W'(band_lvl[b]);
			lv.last = (b == NB - 1);
			pending_levels.push_back(lv);
			res1[b] = 0;
			res2[b] = 0;
		end
		frame_cnt = 0;
	endtask

	// one sample word; valid stays high when no gap follows
	task automatic send_sample(logic [SAMPLE_W-1:0] smp, bit fe);
		s_tdata <= smp;
		s_tlast <= fe;
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		predict_sample(smp, fe);
		words_in++;
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [KEEP_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_GAIN) gain_q = val[GAIN_W-1:0];
		else keep_q = val;
		@(posedge clk);
	endtask

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		case ($urandom_range(3))
			0: return SAMPLE_W'($urandom);
			1: return SAMPLE_W'($signed($urandom_range(512)) - 256);
			2: return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			default: return $urandom_range(1) ? 16'h4000 : 16'hC000;
		endcase
	endfunction

	task automatic random_frames(int count);
		int len;
		int done;
		done = 0;
		while (done < count) begin
			len = $urandom_range(1, 12);
			for (int i = 0; i < len; i++)
				send_sample(pick_sample(), i == len - 1);
			done += len;
		end
	endtask

	// output side: check each accepted word, then choose ready for the next edge
	always @(posedge clk) begin
		band_level_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_levels.size() == 0) begin
				$error("unexpected output word %h", m_tdata);
				errors++;
			end else begin
				want = pending_levels.pop_front();
				if (m_tdata[4:0] !== want.band) begin
					$error("band_index: expected %0d, got %0d", want.band, m_tdata[4:0]);
					errors++;
				end
				if (m_tdata[20:5] !== want.level) begin
					$error("level: expected %0d, got %0d", want.level, m_tdata[20:5]);
					errors++;
				end
				if (m_tlast !== want.last) begin
					$error("last_band: expected %0d, got %0d", want.last, m_tlast);
					errors++;
				end
				if (m_tlast) frames_out++;
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		#40_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		dir_row_t dir_rows [$];
		dir_row_t row;

		for (int b = 0; b < NB; b++) begin
			res1[b] = 0;
			res2[b] = 0;
			band_lvl[b] = 0;
		end
		frame_cnt = 0;
		gain_q = GAIN_RESET;
		keep_q = KEEP_RESET;

		// silence right after reset gives zero everywhere
		dir_rows = '{
			'{16'h0000, 1'b1, 1'b1, 16'd0},
			'{16'h7FFF, 1'b1, 1'b0, 16'd0},
			'{16'h8000, 1'b1, 1'b0, 16'd0},
			'{16'h7FFF, 1'b0, 1'b0, 16'd0},
			'{16'h8000, 1'b0, 1'b0, 16'd0},
			'{16'h7FFF, 1'b0, 1'b0, 16'd0},
			'{16'h8000, 1'b1, 1'b0, 16'd0},
			'{16'h0001, 1'b1, 1'b0, 16'd0},
			'{16'hFFFF, 1'b1, 1'b0, 16'd0},
			'{16'h7FFF, 1'b0, 1'b0, 16'd0},
			'{16'h7FFF, 1'b0, 1'b0, 16'd0},
			'{16'h7FFF, 1'b0, 1'b0, 16'd0},
			'{16'h7FFF, 1'b1, 1'b0, 16'd0},
			'{16'h0000, 1'b1, 1'b0, 16'd0},
			'{16'h0000, 1'b1, 1'b0, 16'd0},
			'{16'h5555, 1'b0, 1'b0, 16'd0},
			'{16'hAAAA, 1'b1, 1'b0, 16'd0}
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			send_sample(row.smp, row.fe);
			if (row.typed)
				for (int k = 1; k <= NB; k++)
					pending_levels[pending_levels.size() - k].level = row.lvl;
		end
		random_frames(40);
		drain();

		// full gain, decay weight above one holds the level
		write_reg(REG_GAIN, 17'd65535);
		write_reg(REG_DECAY_KEEP, 17'h1FFFF);
		// a long run at full scale builds up the low resonators
		for (int i = 0; i < 200; i++)
			send_sample(16'h7FFF, i == 199);
		random_frames(30);
		drain();

		send_idle = 48;
		recv_idle = 24;
		write_reg(REG_GAIN, 17'd0);
		write_reg(REG_DECAY_KEEP, 17'd0);
		random_frames(30);
		drain();

		send_idle = 0;
		recv_idle = 0;
		write_reg(REG_GAIN, 17'd384);
		write_reg(REG_DECAY_KEEP, 17'd32768);
		random_frames(35);
		drain();

		$display("%0d samples sent, %0d band frames checked over four gain/decay settings",
			words_in, frames_out);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
